// ----- design/sbs_pkg.sv -----
// Shared types and constants for the stump best-split search block.
package sbs_pkg;

  localparam int WSumW   = 26;  // weight sums
  localparam int WySumW  = 43;  // weighted target sums
  localparam int ScoreW  = 58;  // score and quotient width
  localparam int DivW    = 85;  // dividend width (square of a magnitude up to 2^42)
  localparam int DivRemW = DivW - ScoreW;  // initial remainder bits
  localparam int MeanW   = 24;
  localparam int ThrW    = 17;
  localparam int XW      = 16;
  localparam int FeatW   = 8;
  localparam int InDataW  = 128;
  localparam int OutDataW = 80;
  localparam int CntW    = $clog2(ScoreW);

  localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, S_MUL, S_SUM, S_START, S_DIV, S_DECIDE, S_FINISH, S_EMIT
  } state_t;

  typedef struct packed {
    logic load_item;   // input request taken
    logic upd_sums;    // move pending sample from right to left
    logic sq_mul;      // partial products of the square
    logic sq_sum;      // add partial products
    logic div_start;
    logic div_mean;    // dividend is 256*|WY| instead of WY^2
    logic side;        // 0 left, 1 right
    logic take_score;
    logic take_mean;
    logic decide;
    logic finish;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic pend_valid;
    logic div_done;
    logic take;
    logic last_round;
    logic out_free;
  } sts_t;

endpackage

// ----- design/sbs_div.sv -----
// Restoring divider, one quotient bit per cycle, saturating at 58 bits.
module sbs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sbs_pkg::DivW-1:0]      dividend,
  input  logic [sbs_pkg::WSumW-1:0]     divisor,
  output logic                          done,
  output logic [sbs_pkg::ScoreW-1:0]    quotient
);
  import sbs_pkg::*;

  logic [DivRemW-1:0] rem_r, rem_nxt;
  logic [ScoreW-1:0]  lo_r, lo_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic               sat_r, sat_nxt;
  logic [DivRemW-1:0] trial;
  logic               fits;

  assign trial = {rem_r[DivRemW-2:0], lo_r[ScoreW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sat_nxt  = sat_r;
    if (start) begin
      rem_nxt = dividend[DivW-1:ScoreW];
      lo_nxt  = dividend[ScoreW-1:0];
      cnt_nxt = '0;
      sat_nxt = dividend[DivW-1:ScoreW] >= {1'b0, divisor};
      // quotient would not fit: finish at once
      busy_nxt = !sat_nxt;
      done_nxt = sat_nxt;
    end else if (busy_r) begin
      rem_nxt = fits ? trial - {1'b0, divisor} : trial;
      lo_nxt  = {lo_r[ScoreW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(ScoreW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    cnt_r <= cnt_nxt;
    sat_r <= sat_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = sat_r ? ScoreMax : lo_r;

endmodule

// ----- design/sbs_ctrl.sv -----
// Sequencer that steps the datapath through one sample.
module sbs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_begin,
  output logic          in_tready,
  input  sbs_pkg::sts_t sts,
  output sbs_pkg::cmd_t cmd
);
  import sbs_pkg::*;

  state_t state_r, state_nxt;
  logic   side_r, side_nxt;
  logic   mean_r, mean_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      side_r  <= 1'b0;
      mean_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      side_r  <= side_nxt;
      mean_r  <= mean_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    side_nxt  = side_r;
    mean_nxt  = mean_r;
    cmd       = '0;
    cmd.side     = side_r;
    cmd.div_mean = mean_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          if (!in_begin) state_nxt = sts.pend_valid ? S_UPD : S_FINISH;
        end
      end
      S_UPD: begin
        cmd.upd_sums = 1'b1;
        side_nxt  = 1'b0;
        mean_nxt  = 1'b0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.sq_mul = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sq_sum = 1'b1;
        state_nxt  = S_START;
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (!mean_r) begin
            cmd.take_score = 1'b1;
            side_nxt  = 1'b1;
            state_nxt = side_r ? S_DECIDE : S_MUL;
          end else begin
            cmd.take_mean = 1'b1;
            side_nxt  = 1'b1;
            state_nxt = side_r ? S_FINISH : S_START;
          end
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.take) begin
          mean_nxt  = 1'b1;
          side_nxt  = 1'b0;
          state_nxt = S_START;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = sts.last_round ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- design/sbs_dp.sv -----
// Datapath: sums, pending sample, squaring, divider, best split, output register.
module sbs_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [sbs_pkg::InDataW-1:0]    in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [sbs_pkg::OutDataW-1:0]   out_tdata,
  output logic                           out_tuser,
  input  sbs_pkg::cmd_t                  cmd,
  output sbs_pkg::sts_t                  sts
);
  import sbs_pkg::*;

  logic [FeatW-1:0]          cur_feat_r;
  logic signed [XW-1:0]      cur_x_r, cur_y_r;
  logic [XW-1:0]             cur_w_r;
  logic                      cur_lf_r, cur_lr_r;
  logic [WSumW-1:0]          tot_w_r, lw_r, rw_r;
  logic signed [WySumW-1:0]  tot_wy_r, lwy_r, rwy_r;
  logic signed [XW-1:0]      pend_x_r, pend_y_r;
  logic [XW-1:0]             pend_w_r;
  logic                      pend_v_r;
  logic [ScoreW-1:0]         best_score_r, s1_r, s2_r;
  logic                      best_found_r;
  logic [FeatW-1:0]          best_feat_r;
  logic signed [ThrW-1:0]    best_thr_r;
  logic signed [MeanW-1:0]   best_lm_r, best_rm_r;
  logic [21:0]               paa_r;
  logic [42:0]               pab_r;
  logic [63:0]               pbb_r;
  logic [DivW-1:0]           sq_r;
  logic                      out_valid_r;
  logic [OutDataW-1:0]       out_data_r;
  logic                      out_found_r;

  logic signed [WySumW-1:0]  sel_wy;
  logic [WSumW-1:0]          sel_w;
  logic [WySumW-1:0]         sel_mag;
  logic signed [32:0]        wy_prod;
  logic signed [WySumW-1:0]  wy_ext;
  logic [DivW-1:0]           dividend;
  logic                      div_done;
  logic [ScoreW-1:0]         quot;
  logic [ScoreW:0]           score_sum;
  logic [ScoreW-1:0]         score;
  logic                      take;
  logic signed [MeanW-1:0]   mean_val;

  assign sel_wy  = cmd.side ? rwy_r : lwy_r;
  assign sel_w   = cmd.side ? rw_r : lw_r;
  assign sel_mag = sel_wy[WySumW-1] ? WySumW'(-sel_wy) : WySumW'(sel_wy);
  assign wy_prod = $signed({1'b0, pend_w_r}) * pend_y_r;
  assign wy_ext  = WySumW'(wy_prod);
  assign dividend = cmd.div_mean ? {{(DivW-WySumW-8){1'b0}}, sel_mag, 8'd0} : sq_r;

  sbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (sel_w),
    .done     (div_done),
    .quotient (quot)
  );

  assign score_sum = {1'b0, s1_r} + {1'b0, s2_r};
  assign score     = score_sum[ScoreW] ? ScoreMax : score_sum[ScoreW-1:0];
  assign take      = (!best_found_r || score > best_score_r) && (pend_x_r != cur_x_r);

  // Q.8 mean, truncated toward zero and clamped to 24 signed bits
  always_comb begin
    if (sel_w == '0) begin
      mean_val = '0;
    end else if (sel_wy[WySumW-1]) begin
      mean_val = (quot >= ScoreW'(1 << (MeanW-1))) ? {1'b1, {(MeanW-1){1'b0}}}
                                                    : -$signed(quot[MeanW-1:0]);
    end else begin
      mean_val = (quot > ScoreW'((1 << (MeanW-1)) - 1)) ? {1'b0, {(MeanW-1){1'b1}}}
                                                         : $signed(quot[MeanW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_w_r <= '0; tot_wy_r <= '0;
      lw_r <= '0; lwy_r <= '0; rw_r <= '0; rwy_r <= '0;
      pend_x_r <= '0; pend_w_r <= '0; pend_y_r <= '0; pend_v_r <= 1'b0;
      best_score_r <= '0; best_found_r <= 1'b0; best_feat_r <= '0;
      best_thr_r <= '0; best_lm_r <= '0; best_rm_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (cmd.load_item) begin
        cur_feat_r <= in_tdata[7:0];
        cur_x_r    <= in_tdata[23:8];
        cur_w_r    <= in_tdata[39:24];
        cur_y_r    <= in_tdata[55:40];
        cur_lf_r   <= in_tuser[1];
        cur_lr_r   <= in_tlast;
        if (!in_tuser[0]) begin
          tot_w_r  <= in_tdata[81:56];
          tot_wy_r <= WySumW'($signed(in_tdata[123:82]));
          lw_r  <= '0;
          lwy_r <= '0;
          rw_r  <= in_tdata[81:56];
          rwy_r <= WySumW'($signed(in_tdata[123:82]));
          pend_v_r <= 1'b0;
          best_score_r <= '0; best_found_r <= 1'b0; best_feat_r <= '0;
          best_thr_r <= '0; best_lm_r <= '0; best_rm_r <= '0;
        end
      end
      if (cmd.upd_sums) begin
        lw_r  <= lw_r + WSumW'(pend_w_r);
        rw_r  <= rw_r - WSumW'(pend_w_r);
        lwy_r <= lwy_r + wy_ext;
        rwy_r <= rwy_r - wy_ext;
      end
      if (cmd.decide && take) begin
        best_score_r <= score;
        best_found_r <= 1'b1;
        best_feat_r  <= cur_feat_r;
        best_thr_r   <= ThrW'(pend_x_r) + ThrW'(cur_x_r);
      end
      if (cmd.take_mean) begin
        if (cmd.side) best_rm_r <= mean_val;
        else          best_lm_r <= mean_val;
      end
      if (cmd.finish) begin
        pend_x_r <= cur_x_r;
        pend_w_r <= cur_w_r;
        pend_y_r <= cur_y_r;
        pend_v_r <= !(cur_lf_r || cur_lr_r);
        if (cur_lf_r || cur_lr_r) begin
          lw_r  <= '0;
          lwy_r <= '0;
          rw_r  <= tot_w_r;
          rwy_r <= tot_wy_r;
        end
      end
      if (cmd.emit) begin
        pend_v_r    <= 1'b0;
        best_score_r <= '0; best_found_r <= 1'b0; best_feat_r <= '0;
        best_thr_r <= '0; best_lm_r <= '0; best_rm_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    // square of |WY| from three partial products; |WY| <= 2^42 keeps a*a in 21 bits
    if (cmd.sq_mul) begin
      paa_r <= sel_mag[42:32] * sel_mag[42:32];
      pab_r <= sel_mag[42:32] * sel_mag[31:0];
      pbb_r <= sel_mag[31:0] * sel_mag[31:0];
    end
    if (cmd.sq_sum)
      sq_r <= {paa_r[20:0], 64'd0} + {9'd0, pab_r, 33'd0} + {21'd0, pbb_r};
    if (cmd.take_score) begin
      if (cmd.side) s2_r <= (sel_w == '0) ? '0 : quot;
      else          s1_r <= (sel_w == '0) ? '0 : quot;
    end
    if (cmd.emit) begin
      out_found_r <= best_found_r;
      out_data_r  <= {7'd0, best_rm_r, best_lm_r, best_thr_r, best_feat_r};
    end
  end

  assign sts.pend_valid = pend_v_r;
  assign sts.div_done   = div_done;
  assign sts.take       = take;
  assign sts.last_round = cur_lr_r;
  assign sts.out_free   = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule

// ----- design/stump_best_split_search.sv -----
// Decision-stump split search over weighted samples. A begin request (in_tuser[0]=0)
// loads the round totals. A sample request is processed one at a time: with no earlier
// sample in its column it goes straight to the finish step; otherwise the two score
// terms each take a squaring and a pass of the shared bit-serial divider (one quotient
// bit per cycle over 58 bits, ending early when the quotient saturates), and a new
// best split adds two more divider passes for the Q.8 means. The last sample of the
// round adds a step to hand over the result. The result sits in an output register;
// the block goes on taking requests while it waits, unless a second result is ready.
module stump_best_split_search (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // feature_index, sample_x, sample_weight, sample_target, total_weight,
  // total_weighted_target, 4'b0
  input  logic [sbs_pkg::InDataW-1:0]   in_tdata,
  input  logic [1:0]                    in_tuser,   // action, last_in_feature
  input  logic                          in_tlast,   // last_in_round
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // best_feature, threshold_doubled, left_mean, right_mean, 7'b0
  output logic [sbs_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tuser   // split_found
);
  import sbs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_begin  (!in_tuser[0]),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sbs_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- design/sbs_checker.sv -----
// Port-level checks for the stump best-split search, bound to the top level.
module sbs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic [1:0]                    in_tuser,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [sbs_pkg::OutDataW-1:0]  out_tdata,
  input logic                          out_tuser
);
  import sbs_pkg::*;

  // a begin request completes in its own cycle
  a_begin_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> in_tready)
    else $error("not ready after begin request");

  // a round with no split reports all-zero fields
  a_nosplit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("nonzero result without split");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind stump_best_split_search sbs_checker u_sbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
